@@ rtl/dmdr_pkg.sv @@
// ----------------------------------------------------------------------------
// dmdr_pkg - shared types and constants for dual mouse dead reckoning
// Sequencer states, multiply operation codes, unit request structs, fixed
// point constants and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package dmdr_pkg;

	// pi and pi/2 in radians Q3.28
	localparam logic signed [31:0] PI_Q      = 32'sd843314857;
	localparam logic signed [31:0] HALF_PI_Q = 32'sd421657428;
	// CORDIC gain correction, Q30
	localparam logic [31:0] CORDIC_K_Q30 = 32'd652032874;
	// cap on the raw heading step magnitude, 2^40
	localparam logic [40:0] STEP_CAP = 41'h100_0000_0000;

	// rotation datapath width
	localparam int XY_W = 51;

	// product shifts
	localparam logic [4:0] SH_NONE  = 5'd0;
	localparam logic [4:0] SH_TURN  = 5'd21;
	localparam logic [4:0] SH_GAIN  = 5'd16;
	localparam logic [4:0] SH_SPEED = 5'd9;
	localparam logic [4:0] SH_K     = 5'd30;

	// configuration register indexes
	localparam logic [2:0] CFG_COUNT_SCALE    = 3'd0;
	localparam logic [2:0] CFG_INV_Y_BASELINE = 3'd1;
	localparam logic [2:0] CFG_INV_X_BASELINE = 3'd2;
	localparam logic [2:0] CFG_GAIN_NEGATIVE  = 3'd3;
	localparam logic [2:0] CFG_GAIN_POSITIVE  = 3'd4;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIFF,
		ST_MGO,
		ST_MWAIT,
		ST_ROT_GO,
		ST_ROT_WAIT,
		ST_OUT
	} state_t;

	typedef enum logic [2:0] {
		OP_TURN_X,
		OP_TURN_Y,
		OP_SCALE,
		OP_GAIN,
		OP_FWD,
		OP_SIDE,
		OP_KX,
		OP_KY
	} op_t;

	typedef enum logic [1:0] {
		MP_IDLE,
		MP_LO,
		MP_HI,
		MP_SUM
	} mul_phase_t;

	typedef struct packed {
		logic        start;
		logic [63:0] m;
		logic [31:0] k;
		logic [4:0]  sh;
	} mul_req_t;

	typedef struct packed {
		logic                   start;
		logic signed [XY_W-1:0] x;
		logic signed [XY_W-1:0] y;
		logic signed [31:0]     phi;
	} rot_req_t;

	function automatic logic signed [31:0] atan_q28(input logic [4:0] i);
		logic signed [31:0] r;
		unique case (i)
			5'd0:  r = 32'sd210828714;
			5'd1:  r = 32'sd124459457;
			5'd2:  r = 32'sd65760959;
			5'd3:  r = 32'sd33381290;
			5'd4:  r = 32'sd16755422;
			5'd5:  r = 32'sd8385879;
			5'd6:  r = 32'sd4193963;
			5'd7:  r = 32'sd2097109;
			5'd8:  r = 32'sd1048571;
			5'd9:  r = 32'sd524287;
			5'd10: r = 32'sd262144;
			5'd11: r = 32'sd131072;
			5'd12: r = 32'sd65536;
			5'd13: r = 32'sd32768;
			5'd14: r = 32'sd16384;
			5'd15: r = 32'sd8192;
			5'd16: r = 32'sd4096;
			5'd17: r = 32'sd2048;
			5'd18: r = 32'sd1024;
			5'd19: r = 32'sd512;
			5'd20: r = 32'sd256;
			5'd21: r = 32'sd128;
			5'd22: r = 32'sd64;
			5'd23: r = 32'sd32;
			5'd24: r = 32'sd16;
			5'd25: r = 32'sd8;
			5'd26: r = 32'sd4;
			5'd27: r = 32'sd2;
			5'd28: r = 32'sd1;
			default: r = 32'sd0;
		endcase
		return r;
	endfunction

endpackage

@@ rtl/dmdr_mul.sv @@
// ----------------------------------------------------------------------------
// dmdr_mul - shared multiply and shift unit
// Computes floor(m * k / 2^sh) for a 64-bit m and 32-bit k with one
// 32x32 multiplier used for the low and the high half in turn.
// ----------------------------------------------------------------------------
module dmdr_mul (
	input  logic              clk,
	input  logic              arst_n,
	input  dmdr_pkg::mul_req_t req,
	output logic              done,
	output logic [63:0]       res
);

	dmdr_pkg::mul_phase_t phase_q;
	logic [63:0] m_q;
	logic [31:0] k_q;
	logic [4:0]  sh_q;
	logic [63:0] lo_q;
	logic [63:0] hi_q;
	logic [31:0] mop;
	logic [63:0] prod;
	logic [95:0] full;
	logic        done_q;
	logic [63:0] res_q;

	assign mop  = (phase_q == dmdr_pkg::MP_HI) ? m_q[63:32] : m_q[31:0];
	assign prod = 64'(mop) * 64'(k_q);
	assign full = {hi_q, 32'b0} + 96'(lo_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= dmdr_pkg::MP_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= (phase_q == dmdr_pkg::MP_SUM);
			unique case (phase_q)
				dmdr_pkg::MP_IDLE: if (req.start) phase_q <= dmdr_pkg::MP_LO;
				dmdr_pkg::MP_LO:   phase_q <= dmdr_pkg::MP_HI;
				dmdr_pkg::MP_HI:   phase_q <= dmdr_pkg::MP_SUM;
				dmdr_pkg::MP_SUM:  phase_q <= dmdr_pkg::MP_IDLE;
				default: phase_q <= dmdr_pkg::MP_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (phase_q == dmdr_pkg::MP_IDLE && req.start) begin
			m_q  <= req.m;
			k_q  <= req.k;
			sh_q <= req.sh;
		end
		if (phase_q == dmdr_pkg::MP_LO) lo_q <= prod;
		if (phase_q == dmdr_pkg::MP_HI) hi_q <= prod;
		if (phase_q == dmdr_pkg::MP_SUM) res_q <= 64'(full >> sh_q);
	end

	assign done = done_q;
	assign res  = res_q;

endmodule

@@ rtl/dmdr_cordic.sv @@
// ----------------------------------------------------------------------------
// dmdr_cordic - iterative CORDIC rotator
// Quarter-turn pre-rotation at start, then one shift-add step per cycle.
// ----------------------------------------------------------------------------
module dmdr_cordic #(
	parameter int STEPS = 24
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  dmdr_pkg::rot_req_t               req,
	output logic                             done,
	output logic signed [dmdr_pkg::XY_W-1:0] x_out,
	output logic signed [dmdr_pkg::XY_W-1:0] y_out
);

	localparam int IW = $clog2(STEPS + 1);

	logic                             busy_q;
	logic                             done_q;
	logic [IW-1:0]                    i_q;
	logic signed [dmdr_pkg::XY_W-1:0] x_q;
	logic signed [dmdr_pkg::XY_W-1:0] y_q;
	logic signed [31:0]               phi_q;
	logic signed [dmdr_pkg::XY_W-1:0] xs;
	logic signed [dmdr_pkg::XY_W-1:0] ys;
	logic signed [31:0]               at;

	assign xs = x_q >>> i_q;
	assign ys = y_q >>> i_q;
	assign at = dmdr_pkg::atan_q28(5'(i_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			i_q    <= '0;
		end else begin
			done_q <= !req.start && busy_q && (i_q == IW'(STEPS - 1));
			if (req.start) begin
				busy_q <= 1'b1;
				i_q    <= '0;
			end else if (busy_q) begin
				if (i_q == IW'(STEPS - 1)) begin
					busy_q <= 1'b0;
				end else begin
					i_q <= i_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			if (req.phi > dmdr_pkg::HALF_PI_Q) begin
				x_q   <= -req.y;
				y_q   <= req.x;
				phi_q <= req.phi - dmdr_pkg::HALF_PI_Q;
			end else if (req.phi < -dmdr_pkg::HALF_PI_Q) begin
				x_q   <= req.y;
				y_q   <= -req.x;
				phi_q <= req.phi + dmdr_pkg::HALF_PI_Q;
			end else begin
				x_q   <= req.x;
				y_q   <= req.y;
				phi_q <= req.phi;
			end
		end else if (busy_q) begin
			if (!phi_q[31]) begin
				x_q   <= x_q - ys;
				y_q   <= y_q + xs;
				phi_q <= phi_q - at;
			end else begin
				x_q   <= x_q + ys;
				y_q   <= y_q - xs;
				phi_q <= phi_q + at;
			end
		end
	end

	assign done  = done_q;
	assign x_out = x_q;
	assign y_out = y_q;

endmodule

@@ rtl/dual_mouse_dead_reckoning_top.sv @@
// ----------------------------------------------------------------------------
// dual_mouse_dead_reckoning_top - dual optical mouse dead reckoning
// A request runs through one difference step, eight passes through the shared
// multiplier, a CORDIC rotation and a load of the result register. The next
// request is taken only once the last is through: input stalls while a request
// runs and while a finished result waits for the result register.
// Reset clears stored counts, heading and position, and loads default config.
// ----------------------------------------------------------------------------
module dual_mouse_dead_reckoning_top #(
	parameter int COUNT_WIDTH  = 32,
	parameter int CORDIC_STEPS = 24
) (
	input  logic               clk,
	input  logic               arst_n,
	// report channel
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [31:0] mouse1_x,
	input  logic signed [31:0] mouse1_y,
	input  logic signed [31:0] mouse2_x,
	input  logic signed [31:0] mouse2_y,
	input  logic               motion_enabled,
	// result channel
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [47:0] pos_x,
	output logic signed [47:0] pos_y,
	output logic signed [30:0] heading,
	output logic signed [30:0] heading_step,
	// configuration write channel
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [23:0]        cfg_data
);

	localparam int XW = dmdr_pkg::XY_W;

	// configuration registers
	logic [23:0] count_scale_q;
	logic [23:0] inv_y_q;
	logic [23:0] inv_x_q;
	logic [16:0] gain_neg_q;
	logic [16:0] gain_pos_q;

	// sequencer
	dmdr_pkg::state_t state_q, state_d;
	dmdr_pkg::op_t    op_q;

	// per-request working registers
	logic [COUNT_WIDTH-1:0] last_q [4];
	logic signed [31:0]     d_q [4];
	logic signed [33:0]     sx_q, sy_q, vd_q, sd_q;
	logic signed [59:0]     px_q;
	logic signed [59:0]     a_q;
	logic [40:0]            m_q;
	logic                   gneg_q;
	logic signed [30:0]     step_q;
	logic signed [XW-1:0]   v_q, s_q;

	// state carried between requests
	logic signed [30:0] heading_q;
	logic signed [47:0] x_acc_q, y_acc_q;

	// result register
	logic               out_valid_q;
	logic signed [47:0] pos_x_q, pos_y_q;
	logic signed [30:0] heading_o_q, step_o_q;

	// unit connections
	dmdr_pkg::mul_req_t mreq;
	logic               mdone;
	logic [63:0]        mres;
	dmdr_pkg::rot_req_t rreq;
	logic               rdone;
	logic signed [XW-1:0] cx, cy;

	logic               accept;
	logic signed [31:0] cnt [4];
	logic signed [31:0] d_new [4];

	// mixed signed operand as magnitude
	function automatic logic [63:0] mag64(input logic signed [63:0] v);
		return v[63] ? 64'(-v) : 64'(v);
	endfunction

	// signed result from a magnitude and a sign
	function automatic logic signed [XW-1:0] apply_sign(input logic neg, input logic [63:0] r);
		return neg ? -XW'(r) : XW'(r);
	endfunction

	// add a rotated component and clamp to the 48-bit range
	function automatic logic signed [47:0] sat_add(input logic signed [47:0] acc,
			input logic signed [XW-1:0] inc);
		logic signed [XW:0] sum;
		sum = (XW+1)'(acc) + (XW+1)'(inc);
		if (sum > (XW+1)'(48'sh7FFF_FFFF_FFFF)) return 48'sh7FFF_FFFF_FFFF;
		if (sum < (XW+1)'(48'sh8000_0000_0000)) return 48'sh8000_0000_0000;
		return 48'(sum);
	endfunction

	assign cfg_ready = 1'b1;
	assign accept    = in_valid && !in_stall;

	assign cnt[0] = mouse1_x;
	assign cnt[1] = mouse1_y;
	assign cnt[2] = mouse2_x;
	assign cnt[3] = mouse2_y;

	// deltas: old minus new, wrapped to the counter width, zero when motion is off
	always_comb begin
		logic [COUNT_WIDTH-1:0]        diff;
		logic signed [COUNT_WIDTH-1:0] ds;
		for (int i = 0; i < 4; i++) begin
			diff     = last_q[i] - cnt[i][COUNT_WIDTH-1:0];
			ds       = diff;
			d_new[i] = motion_enabled ? 32'(ds) : 32'sd0;
		end
	end

	// select operands of the shared multiplier by operation
	always_comb begin
		mreq.start = (state_q == dmdr_pkg::ST_MGO);
		mreq.m     = '0;
		mreq.k     = 32'(count_scale_q);
		mreq.sh    = dmdr_pkg::SH_NONE;
		unique case (op_q)
			dmdr_pkg::OP_TURN_X: begin
				mreq.m = mag64(64'(sx_q));
				mreq.k = 32'(inv_x_q);
			end
			dmdr_pkg::OP_TURN_Y: begin
				mreq.m = mag64(64'(sy_q));
				mreq.k = 32'(inv_y_q);
			end
			dmdr_pkg::OP_SCALE: begin
				mreq.m  = mag64(64'(a_q));
				mreq.sh = dmdr_pkg::SH_TURN;
			end
			dmdr_pkg::OP_GAIN: begin
				mreq.m  = 64'(m_q);
				mreq.k  = gneg_q ? 32'(gain_neg_q) : 32'(gain_pos_q);
				mreq.sh = dmdr_pkg::SH_GAIN;
			end
			dmdr_pkg::OP_FWD: begin
				mreq.m  = mag64(64'(vd_q));
				mreq.sh = dmdr_pkg::SH_SPEED;
			end
			dmdr_pkg::OP_SIDE: begin
				mreq.m  = mag64(64'(sd_q));
				mreq.sh = dmdr_pkg::SH_SPEED;
			end
			dmdr_pkg::OP_KX: begin
				mreq.m  = mag64(64'(cx));
				mreq.k  = dmdr_pkg::CORDIC_K_Q30;
				mreq.sh = dmdr_pkg::SH_K;
			end
			dmdr_pkg::OP_KY: begin
				mreq.m  = mag64(64'(cy));
				mreq.k  = dmdr_pkg::CORDIC_K_Q30;
				mreq.sh = dmdr_pkg::SH_K;
			end
			default: mreq.m = '0;
		endcase
	end

	// rotate the (forward, -side) vector by minus the heading
	assign rreq.start = (state_q == dmdr_pkg::ST_ROT_GO);
	assign rreq.x     = v_q;
	assign rreq.y     = -s_q;
	assign rreq.phi   = -(32'(heading_q));

	dmdr_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mreq),
		.done   (mdone),
		.res    (mres)
	);

	dmdr_cordic #(
		.STEPS (CORDIC_STEPS)
	) u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (rreq),
		.done   (rdone),
		.x_out  (cx),
		.y_out  (cy)
	);

	// next state and handshake
	always_comb begin
		state_d  = state_q;
		in_stall = (state_q != dmdr_pkg::ST_IDLE);
		unique case (state_q)
			dmdr_pkg::ST_IDLE:  if (in_valid) state_d = dmdr_pkg::ST_DIFF;
			dmdr_pkg::ST_DIFF:  state_d = dmdr_pkg::ST_MGO;
			dmdr_pkg::ST_MGO:   state_d = dmdr_pkg::ST_MWAIT;
			dmdr_pkg::ST_MWAIT: begin
				if (mdone) begin
					if (op_q == dmdr_pkg::OP_SIDE)    state_d = dmdr_pkg::ST_ROT_GO;
					else if (op_q == dmdr_pkg::OP_KY) state_d = dmdr_pkg::ST_OUT;
					else                              state_d = dmdr_pkg::ST_MGO;
				end
			end
			dmdr_pkg::ST_ROT_GO:   state_d = dmdr_pkg::ST_ROT_WAIT;
			dmdr_pkg::ST_ROT_WAIT: if (rdone) state_d = dmdr_pkg::ST_MGO;
			// hold until the previous result has been taken
			dmdr_pkg::ST_OUT: if (!out_valid_q || !out_stall) state_d = dmdr_pkg::ST_IDLE;
			default: state_d = dmdr_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= dmdr_pkg::ST_IDLE;
		else         state_q <= state_d;
	end

	// configuration, accumulated state and result handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_scale_q <= 24'd532677;
			inv_y_q       <= 24'd120699;
			inv_x_q       <= 24'd223696;
			gain_neg_q    <= 17'd63570;
			gain_pos_q    <= 17'd50463;
			for (int i = 0; i < 4; i++) last_q[i] <= '0;
			heading_q   <= '0;
			x_acc_q     <= '0;
			y_acc_q     <= '0;
			out_valid_q <= 1'b0;
			op_q        <= dmdr_pkg::OP_TURN_X;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					dmdr_pkg::CFG_COUNT_SCALE:    count_scale_q <= cfg_data;
					dmdr_pkg::CFG_INV_Y_BASELINE: inv_y_q       <= cfg_data;
					dmdr_pkg::CFG_INV_X_BASELINE: inv_x_q       <= cfg_data;
					dmdr_pkg::CFG_GAIN_NEGATIVE:  gain_neg_q    <= cfg_data[16:0];
					dmdr_pkg::CFG_GAIN_POSITIVE:  gain_pos_q    <= cfg_data[16:0];
					default: ;
				endcase
			end

			// load a new result, or drop the taken one
			if (state_q == dmdr_pkg::ST_OUT && (!out_valid_q || !out_stall))
				out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;

			// store counters even when motion is off
			if (accept) begin
				for (int i = 0; i < 4; i++) last_q[i] <= cnt[i][COUNT_WIDTH-1:0];
			end

			if (state_q == dmdr_pkg::ST_DIFF) op_q <= dmdr_pkg::OP_TURN_X;
			if (state_q == dmdr_pkg::ST_ROT_WAIT && rdone) op_q <= dmdr_pkg::OP_KX;

			if (state_q == dmdr_pkg::ST_MWAIT && mdone) begin
				unique case (op_q)
					dmdr_pkg::OP_TURN_X: op_q <= dmdr_pkg::OP_TURN_Y;
					dmdr_pkg::OP_TURN_Y: op_q <= dmdr_pkg::OP_SCALE;
					dmdr_pkg::OP_SCALE:  op_q <= dmdr_pkg::OP_GAIN;
					dmdr_pkg::OP_GAIN:   op_q <= dmdr_pkg::OP_FWD;
					dmdr_pkg::OP_FWD: begin
						logic signed [31:0] hs;
						hs = 32'(heading_q) + 32'(step_q);
						// wrap the heading back into [-pi, pi)
						if (hs > dmdr_pkg::PI_Q - 32'sd1)
							heading_q <= 31'(hs - (dmdr_pkg::PI_Q <<< 1));
						else if (hs < -dmdr_pkg::PI_Q)
							heading_q <= 31'(hs + (dmdr_pkg::PI_Q <<< 1));
						else
							heading_q <= 31'(hs);
						op_q <= dmdr_pkg::OP_SIDE;
					end
					dmdr_pkg::OP_SIDE: op_q <= dmdr_pkg::OP_KX;
					dmdr_pkg::OP_KX: begin
						x_acc_q <= sat_add(x_acc_q, apply_sign(cx[XW-1], mres));
						op_q    <= dmdr_pkg::OP_KY;
					end
					dmdr_pkg::OP_KY: y_acc_q <= sat_add(y_acc_q, apply_sign(cy[XW-1], mres));
					default: op_q <= dmdr_pkg::OP_TURN_X;
				endcase
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			for (int i = 0; i < 4; i++) d_q[i] <= d_new[i];
		end

		if (state_q == dmdr_pkg::ST_DIFF) begin
			sx_q <= -34'(d_q[2]) - 34'(d_q[0]);
			sy_q <= 34'(d_q[3]) + 34'(d_q[1]);
			vd_q <= 34'(d_q[3]) - 34'(d_q[1]);
			sd_q <= 34'(d_q[0]) - 34'(d_q[2]);
		end

		if (state_q == dmdr_pkg::ST_MWAIT && mdone) begin
			case (op_q)
				dmdr_pkg::OP_TURN_X: px_q <= sx_q[33] ? -60'(mres) : 60'(mres);
				dmdr_pkg::OP_TURN_Y: a_q  <= px_q - (sy_q[33] ? -60'(mres) : 60'(mres));
				dmdr_pkg::OP_SCALE: begin
					m_q    <= (mres > 64'(dmdr_pkg::STEP_CAP)) ? dmdr_pkg::STEP_CAP : mres[40:0];
					gneg_q <= a_q[59] && (mres != 64'd0);
				end
				dmdr_pkg::OP_GAIN: begin
					// clamp the step to the heading range
					if (gneg_q)
						step_q <= (mres > 64'(dmdr_pkg::PI_Q)) ? -31'(dmdr_pkg::PI_Q)
							: -31'(mres);
					else
						step_q <= (mres > 64'(dmdr_pkg::PI_Q - 32'sd1))
							? 31'(dmdr_pkg::PI_Q - 32'sd1) : 31'(mres);
				end
				dmdr_pkg::OP_FWD:  v_q <= apply_sign(vd_q[33], mres);
				dmdr_pkg::OP_SIDE: s_q <= apply_sign(sd_q[33], mres);
				default: ;
			endcase
		end

		if (state_q == dmdr_pkg::ST_OUT && (!out_valid_q || !out_stall)) begin
			pos_x_q     <= x_acc_q;
			pos_y_q     <= y_acc_q;
			heading_o_q <= heading_q;
			step_o_q    <= step_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign pos_x        = pos_x_q;
	assign pos_y        = pos_y_q;
	assign heading      = heading_o_q;
	assign heading_step = step_o_q;

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top - self-checking bench for dual mouse dead reckoning
// Feeds mouse counter reports through a bursty driver, stalls the result side
// on its own pattern, and checks every fix against an in-bench odometry
// predictor across several register settings.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int          CORDIC_N   = 24;
	localparam int          SETTLE     = 120;       // cycles past the last fix
	localparam int          CYCLE_CAP  = 1000000;
	localparam int          LONG_HOLD  = 500;
	localparam logic [2:0]  CFG_NONE   = 3'd7;      // unused register index
	localparam logic [63:0] MUL_SAT    = 64'h4000_0000_0000_0000;
	localparam logic [63:0] TURN_CAP   = 64'h100_0000_0000;
	localparam logic signed [63:0] PI_W   = 64'sd843314857;
	localparam logic signed [63:0] HPI_W  = 64'sd421657428;
	localparam logic signed [63:0] POS_HI = 64'sd140737488355327;
	localparam logic signed [63:0] POS_LO = -64'sd140737488355328;

	typedef struct {
		logic signed [31:0] m1x, m1y, m2x, m2y;
		logic               en;
	} report_t;

	typedef struct {
		logic signed [47:0] px, py;
		logic signed [30:0] hd, hstep;
	} fix_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0, in_stall;
	logic signed [31:0] mouse1_x = '0, mouse1_y = '0, mouse2_x = '0, mouse2_y = '0;
	logic motion_enabled = 1'b0;
	logic out_valid, out_stall = 1'b0;
	logic signed [47:0] pos_x, pos_y;
	logic signed [30:0] heading, heading_step;
	logic cfg_valid = 1'b0, cfg_ready;
	logic [2:0] cfg_index = '0;
	logic [23:0] cfg_data = '0;

	dual_mouse_dead_reckoning_top dut (.*);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// predictor state and register copy
	logic [31:0] last_cnt [4];
	logic signed [63:0] hd_acc, px_acc, py_acc;
	logic [23:0] r_scale, r_inv_y, r_inv_x;
	logic [16:0] r_gneg, r_gpos;
	logic signed [63:0] atan_lut [30] = '{210828714, 124459457, 65760959, 33381290,
		16755422, 8385879, 4193963, 2097109, 1048571, 524287, 262144, 131072,
		65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32,
		16, 8, 4, 2, 1, 0};

	report_t pending_reports[$];
	fix_t    expected_fixes[$];
	report_t on_bus;
	int      errors = 0;
	int      burst_left = 0, gap_left = 0;
	int      hold_ask = 0, hold_seen = 0, hold_left = 0;
	int      stall_mode = 0, mode_left = 0;
	int      cycles = 0;
	logic signed [31:0] gen_cnt [4];

	// floor(m*k / 2^sh), capped at 2^62
	function automatic logic [63:0] mul_shift(logic [63:0] m, logic [31:0] k, int sh);
		logic [127:0] p;
		p = ({64'd0, m} * {96'd0, k}) >> sh;
		if (p > {64'd0, MUL_SAT})
			return MUL_SAT;
		return p[63:0];
	endfunction

	// same with sign-magnitude truncation toward zero
	function automatic logic signed [63:0] smul_shift(logic signed [63:0] a,
			logic [31:0] k, int sh);
		logic [63:0] r;
		r = mul_shift(a < 0 ? -a : a, k, sh);
		return a < 0 ? -$signed(r) : $signed(r);
	endfunction

	function automatic void set_register(logic [2:0] idx, logic [23:0] val);
		case (idx)
			dmdr_pkg::CFG_COUNT_SCALE:    r_scale = val;
			dmdr_pkg::CFG_INV_Y_BASELINE: r_inv_y = val;
			dmdr_pkg::CFG_INV_X_BASELINE: r_inv_x = val;
			dmdr_pkg::CFG_GAIN_NEGATIVE:  r_gneg  = val[16:0];
			dmdr_pkg::CFG_GAIN_POSITIVE:  r_gpos  = val[16:0];
			default: ;
		endcase
	endfunction

	// advance the odometry by one report and queue the fix it produces
	function automatic void advance_odometry(report_t rq);
		logic signed [63:0] d [4];
		logic signed [63:0] a, hstep, v, s, x, y, t, phi, xs, ys;
		logic [63:0] m;
		logic [31:0] cur [4];
		logic [31:0] u;
		fix_t f;
		cur = '{rq.m1x, rq.m1y, rq.m2x, rq.m2y};
		for (int i = 0; i < 4; i++) begin
			u = last_cnt[i] - cur[i];
			d[i] = rq.en ? 64'($signed(u)) : 64'sd0;
			last_cnt[i] = cur[i];
		end
		a = (-d[2] - d[0]) * $signed(64'(r_inv_x)) - (d[3] + d[1]) * $signed(64'(r_inv_y));
		m = mul_shift(a < 0 ? -a : a, 32'(r_scale), 21);
		if (m > TURN_CAP)
			m = TURN_CAP;
		if (a < 0 && m != 0) begin
			hstep = -$signed(mul_shift(m, 32'(r_gneg), 16));
			if (hstep < -PI_W)
				hstep = -PI_W;
		end else begin
			hstep = $signed(mul_shift(m, 32'(r_gpos), 16));
			if (hstep > PI_W - 1)
				hstep = PI_W - 1;
		end
		hd_acc = hd_acc + hstep;
		if (hd_acc > PI_W - 1)
			hd_acc = hd_acc - 2 * PI_W;
		else if (hd_acc < -PI_W)
			hd_acc = hd_acc + 2 * PI_W;
		// body speeds, then rotate by minus the heading
		v = smul_shift(d[3] - d[1], 32'(r_scale), 9);
		s = smul_shift(d[0] - d[2], 32'(r_scale), 9);
		x = v;
		y = -s;
		phi = -hd_acc;
		if (phi > HPI_W) begin
			t = x; x = -y; y = t; phi = phi - HPI_W;
		end else if (phi < -HPI_W) begin
			t = x; x = y; y = -t; phi = phi + HPI_W;
		end
		for (int i = 0; i < CORDIC_N; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (phi >= 0) begin
				x = x - ys; y = y + xs; phi = phi - atan_lut[i];
			end else begin
				x = x + ys; y = y - xs; phi = phi + atan_lut[i];
			end
		end
		x = smul_shift(x, dmdr_pkg::CORDIC_K_Q30, 30);
		y = smul_shift(y, dmdr_pkg::CORDIC_K_Q30, 30);
		px_acc = px_acc + x;
		py_acc = py_acc + y;
		if (px_acc > POS_HI) px_acc = POS_HI;
		if (px_acc < POS_LO) px_acc = POS_LO;
		if (py_acc > POS_HI) py_acc = POS_HI;
		if (py_acc < POS_LO) py_acc = POS_LO;
		f.px = px_acc[47:0];
		f.py = py_acc[47:0];
		f.hd = hd_acc[30:0];
		f.hstep = hstep[30:0];
		expected_fixes.push_back(f);
	endfunction

	task automatic report_mismatch(string what, logic signed [63:0] got, logic signed [63:0] want);
		errors++;
		$display("%0t: %s got %0d want %0d", $realtime, what, got, want);
	endtask

	// driver: accept, predict, then offer the next request in bursts
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				advance_odometry(on_bus);
			if (!in_valid || !in_stall) begin
				if (gap_left > 0 || pending_reports.size() == 0) begin
					if (gap_left > 0)
						gap_left--;
					in_valid <= 1'b0;
				end else begin
					on_bus = pending_reports.pop_front();
					mouse1_x <= on_bus.m1x;
					mouse1_y <= on_bus.m1y;
					mouse2_x <= on_bus.m2x;
					mouse2_y <= on_bus.m2y;
					motion_enabled <= on_bus.en;
					in_valid <= 1'b1;
					if (burst_left > 0)
						burst_left--;
					else begin
						burst_left = $urandom_range(0, 10);
						gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 90);
					end
				end
			end
		end
	end

	// monitor: stall pattern, long hold-off on request, and fix checking
	always @(posedge clk) begin
		fix_t f;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (expected_fixes.size() == 0) begin
					report_mismatch("fixes pending", 64'sd1, 64'sd0);
				end else begin
					f = expected_fixes.pop_front();
					if (pos_x !== f.px) report_mismatch("pos_x", 64'(pos_x), 64'(f.px));
					if (pos_y !== f.py) report_mismatch("pos_y", 64'(pos_y), 64'(f.py));
					if (heading !== f.hd)
						report_mismatch("heading", 64'(heading), 64'(f.hd));
					if (heading_step !== f.hstep)
						report_mismatch("heading_step", 64'(heading_step), 64'(f.hstep));
				end
			end
			if (hold_seen != hold_ask) begin
				hold_seen = hold_ask;
				hold_left = LONG_HOLD;
			end
			if (mode_left == 0) begin
				stall_mode = $urandom_range(0, 2);
				mode_left = $urandom_range(20, 200);
			end else
				mode_left--;
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else
				out_stall <= (stall_mode == 0) ? 1'b0 :
					(stall_mode == 1) ? ($urandom_range(0, 3) == 0) : ($urandom_range(0, 3) != 0);
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_CAP) begin
			$display("simulation failed");
			$finish;
		end
	end

	task automatic push_report(logic signed [31:0] a, b, c, e, logic en);
		report_t r;
		r.m1x = a; r.m1y = b; r.m2x = c; r.m2y = e; r.en = en;
		pending_reports.push_back(r);
	endtask

	// random reports: mostly plausible small motion, some jumps and noise
	task automatic queue_random(int n);
		int r;
		for (int k = 0; k < n; k++) begin
			r = $urandom_range(0, 99);
			for (int i = 0; i < 4; i++) begin
				if (r < 70)
					gen_cnt[i] = gen_cnt[i] + (int'($urandom_range(0, 4000)) - 2000);
				else if (r < 85)
					gen_cnt[i] = gen_cnt[i] + $signed($urandom());
				else
					gen_cnt[i] = $urandom();
			end
			push_report(gen_cnt[0], gen_cnt[1], gen_cnt[2], gen_cnt[3],
				r < 70 ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 1) != 0));
		end
	endtask

	// hold until every request is taken and every fix is back
	task automatic drain();
		do
			@(posedge clk);
		while (pending_reports.size() != 0 || in_valid || expected_fixes.size() != 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_register(logic [2:0] idx, logic [23:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do
			@(posedge clk);
		while (!cfg_ready);
		set_register(idx, val);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic write_all(logic [23:0] sc, iy, ix, gn, gp);
		write_register(dmdr_pkg::CFG_COUNT_SCALE, sc);
		write_register(dmdr_pkg::CFG_INV_Y_BASELINE, iy);
		write_register(dmdr_pkg::CFG_INV_X_BASELINE, ix);
		write_register(dmdr_pkg::CFG_GAIN_NEGATIVE, gn);
		write_register(dmdr_pkg::CFG_GAIN_POSITIVE, gp);
	endtask

	initial begin
		for (int i = 0; i < 4; i++) begin
			last_cnt[i] = '0;
			gen_cnt[i] = '0;
		end
		hd_acc = 0; px_acc = 0; py_acc = 0;
		r_scale = 24'd532677; r_inv_y = 24'd120699; r_inv_x = 24'd223696;
		r_gneg = 17'd63570; r_gpos = 17'd50463;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: zeros, extremes, motion off, counter wrap, big turns both
		// ways, and a run of large steps that alternate between forward and backward
		push_report(0, 0, 0, 0, 1'b1);
		push_report(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 1'b1);
		push_report(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 1'b1);
		push_report(32'hffffffff, 32'h00000000, 32'hffffffff, 32'h00000000, 1'b0);
		push_report(32'h12345678, 32'hfedcba98, 32'h0f0f0f0f, 32'hf0f0f0f0, 1'b0);
		push_report(32'h12345678, 32'hfedcba98, 32'h0f0f0f0f, 32'hf0f0f0f0, 1'b1);
		push_report(32'h7ffffff0, 32'h7ffffff0, 32'h7ffffff0, 32'h7ffffff0, 1'b1);
		push_report(32'h80000010, 32'h80000010, 32'h80000010, 32'h80000010, 1'b1);
		push_report(32'h00000010, 32'h40000010, 32'h00000010, 32'h40000010, 1'b1);
		push_report(32'hc0000010, 32'h00000010, 32'hc0000010, 32'h00000010, 1'b1);
		for (int k = 0; k < 8; k++)
			push_report(0, (k % 2) ? 32'h7fff0000 : 32'h0, 0,
				(k % 2) ? 32'h0 : 32'h7fff0000, 1'b1);
		push_report(32'h55555555, 32'haaaaaaaa, 32'haaaaaaaa, 32'h55555555, 1'b1);
		push_report(32'haaaaaaaa, 32'h55555555, 32'h55555555, 32'haaaaaaaa, 1'b1);
		drain();
		for (int i = 0; i < 4; i++) gen_cnt[i] = last_cnt[i];

		// defaults, with the long receiver hold-off in the middle
		queue_random(40);
		repeat (200) @(posedge clk);
		hold_ask = hold_ask + 1;
		queue_random(50);
		drain();

		// all registers at their top, gains written with upper bits set
		write_all(24'hffffff, 24'hffffff, 24'hffffff, 24'hffffff, 24'hffffff);
		push_report(gen_cnt[0], gen_cnt[1] - 32'h7fffffff, gen_cnt[2],
			gen_cnt[3] + 32'h7fffffff, 1'b1);
		push_report(gen_cnt[0] + 32'h7fffffff, gen_cnt[1], gen_cnt[2] - 32'h7fffffff,
			gen_cnt[3], 1'b1);
		queue_random(90);
		drain();

		// all registers at zero, plus ignored indexes
		write_all(24'h0, 24'h0, 24'h0, 24'h0, 24'h0);
		write_register(CFG_NONE, 24'hffffff);
		write_register(CFG_NONE - 3'd1, 24'h123456);
		write_register(CFG_NONE - 3'd2, 24'habcdef);
		queue_random(80);
		drain();

		// random settings
		for (int p = 0; p < 3; p++) begin
			write_all(24'($urandom()), 24'($urandom()), 24'($urandom()),
				24'($urandom()), 24'($urandom()));
			queue_random(80);
			drain();
		end

		// back to plain defaults
		write_all(24'd532677, 24'd120699, 24'd223696, 24'd63570, 24'd50463);
		queue_random(60);
		drain();

		if (expected_fixes.size() != 0)
			report_mismatch("fixes never arrived", 64'(expected_fixes.size()), 64'sd0);
		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
